// ===== src/smm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_pkg
// Types and constants shared by the serial memory monitor bridge.
// ----------------------------------------------------------------------------
package smm_pkg;

    localparam int MAX_BEATS = 5;
    localparam int CNT_W     = $clog2(MAX_BEATS + 1);

    // command codes
    localparam logic [7:0] OP_PING  = 8'd1;
    localparam logic [7:0] OP_PEEK  = 8'd2;
    localparam logic [7:0] OP_POKE  = 8'd3;
    localparam logic [7:0] OP_START = 8'd4;
    localparam logic [7:0] OP_GOTO  = 8'd5;
    localparam logic [7:0] OP_CALL  = 8'd6;
    localparam logic [7:0] OP_NULL  = 8'd0;

    localparam logic [7:0] REPLY_OK     = 8'd1;
    localparam logic [7:0] REPLY_REFUSE = 8'd2;

    // input beat kinds
    localparam logic IN_UART = 1'b0;
    localparam logic IN_READ = 1'b1;

    // result beat kinds
    localparam logic [1:0] KIND_TX    = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_XFER  = 2'd3;

    // bus size codes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;
    localparam logic [1:0] SIZE_LONG = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_FLAGS     = 4'd1,
        PH_SIZE      = 4'd2,
        PH_ADDR      = 4'd3,
        PH_LEN       = 4'd4,
        PH_PEEK_WAIT = 4'd5,
        PH_POKE_DATA = 4'd6
    } phase_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  rx_byte;
        logic [31:0] read_data;
    } in_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  tx_byte;
        logic [31:0] bus_address;
        logic [31:0] bus_data;
        logic [1:0]  bus_size;
        logic [1:0]  jump_mode;
        logic        last;
    } out_t;

    // all result beats caused by one input beat
    typedef struct packed {
        logic [CNT_W-1:0]           count;
        out_t [MAX_BEATS-1:0]       beat;
    } burst_t;

endpackage

// ===== src/serial_memory_monitor_bridge_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_memory_monitor_bridge_top
// Memory monitor bridge: parses host command packets, issues bus accesses.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat is either a received host byte (kind 0) or returned
//           bus read data (kind 1). valid/ready handshake.
//   out_* : result beats (transmit byte, bus read request, bus write,
//           control transfer); the final beat caused by an input beat has
//           last set.
//   Path: an accepted input beat is registered in the input register,
//   then processed into the registered result queue, whose slot 0
//   presents its first result; the load waits while the queue is busy.
//   Throughput: one input beat per cycle while each produces at most one
//   result and out_ready stays high. An input beat producing k results
//   holds the queue until all k are taken, as the output port moves one
//   beat per cycle while out_ready is high; the queue takes the next burst in the cycle its final beat is taken.
//   Stall: when out_ready is low the queue holds, the input register
//   fills, and in_ready drops until the queue drains.
//   Reset: rst_n clears the parser to idle (awaiting a command byte) and
//   empties the input register and result queue.
// ----------------------------------------------------------------------------
module serial_memory_monitor_bridge_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  smm_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output smm_pkg::out_t out_data
);
    import smm_pkg::*;

    // input register
    logic       in_valid_reg;
    in_t        in_reg;

    // result queue, slot 0 drives the output
    out_t [MAX_BEATS-1:0] q_reg, q_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    burst_t burst;
    logic   take;
    logic   q_free;
    logic   move;

    assign take      = out_valid && out_ready;
    // queue can accept a burst once empty or on its final beat leaving
    assign q_free    = (cnt_reg == '0) || (cnt_reg == CNT_W'(1) && out_ready);
    assign move      = in_valid_reg && q_free;
    assign in_ready  = !in_valid_reg || move;
    assign out_valid = (cnt_reg != '0);
    assign out_data  = q_reg[0];

    smm_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (move),
        .item  (in_reg),
        .burst (burst)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_reg <= in_data;
    end

    always_comb
    begin
        q_next   = q_reg;
        cnt_next = cnt_reg;
        if (move) begin
            q_next   = burst.beat;
            cnt_next = burst.count;
        end else if (take) begin
            for (int i = 0; i < MAX_BEATS - 1; i++)
                q_next[i] = q_reg[i + 1];
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    // queue never overfills
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_BEATS))
        else $error("result queue count out of range");

    // a loaded burst shows up whole in the queue
    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> cnt_reg == $past(burst.count))
        else $error("queue count does not match loaded burst");

    // a beat without last always has a successor queued
    a_last_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.last) |-> cnt_reg > CNT_W'(1))
        else $error("non-final beat at queue tail");

    // the final queued beat carries last
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == CNT_W'(1)) |-> out_data.last)
        else $error("final queued beat without last");

endmodule

// ===== src/smm_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_engine
// Command parser state and per-beat result generation.
// ----------------------------------------------------------------------------
module smm_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  smm_pkg::in_t   item,
    output smm_pkg::burst_t burst
);
    import smm_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  cmd_reg, cmd_next;
    logic        alt_reg, alt_next;
    logic        block_reg, block_next;
    logic [2:0]  size_reg, size_next;
    logic [31:0] addr_reg, addr_next;
    logic [31:0] rem_reg, rem_next;
    logic [1:0]  idx_reg, idx_next;
    logic [31:0] asm_reg, asm_next;

    logic [31:0] asm_shift;
    logic [31:0] rem_adv;
    logic [31:0] addr_adv;
    logic [1:0]  size_code;
    logic [1:0]  bidx;
    logic [7:0]  b;
    logic [CNT_W-1:0] n;

    function automatic out_t mk(logic [1:0] k, logic [7:0] tx, logic [31:0] a,
                                logic [31:0] d, logic [1:0] sz, logic [1:0] jm);
        out_t r;
        r.out_kind    = k;
        r.tx_byte     = tx;
        r.bus_address = a;
        r.bus_data    = d;
        r.bus_size    = sz;
        r.jump_mode   = jm;
        r.last        = 1'b0;
        return r;
    endfunction

    assign b         = item.rx_byte;
    assign asm_shift = {asm_reg[23:0], b};
    assign size_code = (size_reg == 3'd4) ? SIZE_LONG :
                       (size_reg == 3'd2) ? SIZE_WORD : SIZE_BYTE;

    // element advance: saturating length, address by size / alt / block
    assign rem_adv = (rem_reg > {29'd0, size_reg}) ? rem_reg - {29'd0, size_reg} : 32'd0;
    always_comb
    begin
        if (size_reg == 3'd1 && alt_reg)
            addr_adv = addr_reg + 32'd2;
        else if (!block_reg)
            addr_adv = addr_reg + {29'd0, size_reg};
        else
            addr_adv = addr_reg;
    end

    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        alt_next   = alt_reg;
        block_next = block_reg;
        size_next  = size_reg;
        addr_next  = addr_reg;
        rem_next   = rem_reg;
        idx_next   = idx_reg;
        asm_next   = asm_reg;
        n          = '0;
        bidx       = '0;
        burst.beat = '0;

        if (step) begin
            if (item.kind == IN_READ) begin
                if (phase_reg == PH_PEEK_WAIT) begin
                    // stream the element out most significant byte first
                    for (int i = 0; i < 4; i++) begin
                        bidx = 2'(size_reg - 3'(i) - 3'd1);
                        if (3'(i) < size_reg)
                            burst.beat[i] = mk(KIND_TX, item.read_data[{bidx, 3'b000} +: 8],
                                               32'd0, 32'd0, 2'd0, 2'd0);
                    end
                    n         = CNT_W'(size_reg);
                    rem_next  = rem_adv;
                    addr_next = addr_adv;
                    if (rem_adv != 32'd0) begin
                        for (int i = 0; i < MAX_BEATS; i++) begin
                            if (3'(i) == size_reg)
                                burst.beat[i] = mk(KIND_READ, 8'd0, addr_adv, 32'd0,
                                                   size_code, 2'd0);
                        end
                        n = CNT_W'(size_reg) + CNT_W'(1);
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
            end else begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        priority if (b == OP_NULL) begin
                        end else if (b == OP_PING) begin
                            burst.beat[0] = mk(KIND_TX, REPLY_OK, 32'd0, 32'd0, 2'd0, 2'd0);
                            n = CNT_W'(1);
                        end else if (b == OP_PEEK || b == OP_POKE) begin
                            cmd_next   = b[3:0];
                            phase_next = PH_FLAGS;
                        end else if (b >= OP_START && b <= OP_CALL) begin
                            cmd_next   = b[3:0];
                            idx_next   = '0;
                            asm_next   = '0;
                            phase_next = PH_ADDR;
                        end else begin
                            burst.beat[0] = mk(KIND_TX, REPLY_REFUSE, 32'd0, 32'd0, 2'd0, 2'd0);
                            n = CNT_W'(1);
                        end
                    end
                    PH_FLAGS:
                    begin
                        alt_next   = b[0];
                        block_next = b[1];
                        phase_next = PH_SIZE;
                    end
                    PH_SIZE:
                    begin
                        size_next  = (b == 8'd1 || b == 8'd2 || b == 8'd4) ? b[2:0] : 3'd0;
                        idx_next   = '0;
                        asm_next   = '0;
                        phase_next = PH_ADDR;
                    end
                    PH_ADDR, PH_LEN:
                    begin
                        asm_next = asm_shift;
                        if (idx_reg != 2'd3) begin
                            idx_next = idx_reg + 2'd1;
                        end else begin
                            idx_next = '0;
                            asm_next = '0;
                            if (phase_reg == PH_ADDR) begin
                                addr_next = asm_shift;
                                if (cmd_reg >= OP_START[3:0]) begin
                                    burst.beat[0] = mk(KIND_TX, REPLY_OK, 32'd0, 32'd0,
                                                       2'd0, 2'd0);
                                    burst.beat[1] = mk(KIND_XFER, 8'd0, asm_shift, 32'd0, 2'd0,
                                                       2'(cmd_reg - OP_START[3:0]));
                                    n          = CNT_W'(2);
                                    phase_next = PH_IDLE;
                                end else begin
                                    phase_next = PH_LEN;
                                end
                            end else begin
                                rem_next   = asm_shift;
                                phase_next = PH_IDLE;
                                if (size_reg == 3'd0) begin
                                    // bad size byte: refuse the packet
                                    burst.beat[0] = mk(KIND_TX, REPLY_REFUSE, 32'd0, 32'd0,
                                                       2'd0, 2'd0);
                                    n = CNT_W'(1);
                                end else if (cmd_reg == OP_PEEK[3:0]) begin
                                    burst.beat[0] = mk(KIND_TX, REPLY_OK, 32'd0, 32'd0,
                                                       2'd0, 2'd0);
                                    n = CNT_W'(1);
                                    if (asm_shift != 32'd0) begin
                                        burst.beat[1] = mk(KIND_READ, 8'd0, addr_reg, 32'd0,
                                                           size_code, 2'd0);
                                        n          = CNT_W'(2);
                                        phase_next = PH_PEEK_WAIT;
                                    end
                                end else if (asm_shift == 32'd0) begin
                                    burst.beat[0] = mk(KIND_TX, REPLY_OK, 32'd0, 32'd0,
                                                       2'd0, 2'd0);
                                    n = CNT_W'(1);
                                end else begin
                                    phase_next = PH_POKE_DATA;
                                end
                            end
                        end
                    end
                    PH_POKE_DATA:
                    begin
                        asm_next = asm_shift;
                        if ({1'b0, idx_reg} + 3'd1 < size_reg) begin
                            idx_next = idx_reg + 2'd1;
                        end else begin
                            burst.beat[0] = mk(KIND_WRITE, 8'd0, addr_reg, asm_shift,
                                               size_code, 2'd0);
                            n         = CNT_W'(1);
                            idx_next  = '0;
                            asm_next  = '0;
                            rem_next  = rem_adv;
                            addr_next = addr_adv;
                            if (rem_adv == 32'd0) begin
                                burst.beat[1] = mk(KIND_TX, REPLY_OK, 32'd0, 32'd0,
                                                   2'd0, 2'd0);
                                n          = CNT_W'(2);
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    PH_PEEK_WAIT:
                    begin
                        // host bytes dropped while a read is outstanding
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end

        for (int i = 0; i < MAX_BEATS; i++)
            burst.beat[i].last = (CNT_W'(i) + CNT_W'(1) == n);
        burst.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            cmd_reg   <= '0;
            alt_reg   <= 1'b0;
            block_reg <= 1'b0;
            size_reg  <= '0;
            addr_reg  <= '0;
            rem_reg   <= '0;
            idx_reg   <= '0;
            asm_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            alt_reg   <= alt_next;
            block_reg <= block_next;
            size_reg  <= size_next;
            addr_reg  <= addr_next;
            rem_reg   <= rem_next;
            idx_reg   <= idx_next;
            asm_reg   <= asm_next;
        end
    end

endmodule
